/* hdl/mfpi_pkg.sv */
// Shared types, constants and register codes for the matrix fault pattern injector.
package mfpi_pkg;

	localparam int MAX_ROWS = 4096;
	localparam int MAX_COLS = 4096;
	localparam int POS_W = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS);
	localparam int CNT_W = POS_W + 1;

	localparam logic [CNT_W-1:0] ROWS_LIMIT = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] COLS_LIMIT = CNT_W'(MAX_COLS);

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_MODE   = 3'd1;
	localparam logic [2:0] REG_DELTA  = 3'd2;
	localparam logic [2:0] REG_INDEX  = 3'd3;
	localparam logic [2:0] REG_ROWS   = 3'd4;
	localparam logic [2:0] REG_COLS   = 3'd5;

	localparam logic [1:0] MODE_TRIVIAL   = 2'd1;
	localparam logic [1:0] MODE_CHECKERED = 2'd2;

	localparam logic [31:0] DELTA_RESET  = 32'h3F80_0000;
	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB
	} op_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN
	} div_state_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

/* hdl/mfpi_target.sv */
// Iterative divider that turns the flat target index into a row and a column.
module mfpi_target (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   index,
	input  logic [mfpi_pkg::CNT_W-1:0]    rows,
	input  logic [mfpi_pkg::CNT_W-1:0]    cols,
	output logic                          busy,
	output logic [mfpi_pkg::POS_W-1:0]    target_row,
	output logic [mfpi_pkg::POS_W-1:0]    target_col
);

	mfpi_pkg::div_state_t state_q, state_d;
	logic [30:0]                  quot_q;
	logic [mfpi_pkg::CNT_W-1:0]   rem_q;
	logic [4:0]                   cnt_q;
	logic [mfpi_pkg::CNT_W:0]     trial;
	logic                         fits;
	logic                         last_step;
	logic [30:0]                  quot_next;
	logic [mfpi_pkg::CNT_W-1:0]   rem_next;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfpi_pkg::DIV_IDLE: if (start) state_d = mfpi_pkg::DIV_LOAD;
			mfpi_pkg::DIV_LOAD: state_d = mfpi_pkg::DIV_RUN;
			mfpi_pkg::DIV_RUN:  if (last_step) state_d = mfpi_pkg::DIV_IDLE;
			default:            state_d = mfpi_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != mfpi_pkg::DIV_IDLE);
	end

	assign last_step = (cnt_q == 5'd30);
	assign trial = {rem_q, quot_q[30]};
	assign fits = (trial >= {1'b0, cols});
	assign rem_next = fits ? mfpi_pkg::CNT_W'(trial - {1'b0, cols})
	                       : mfpi_pkg::CNT_W'(trial);
	assign quot_next = {quot_q[29:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mfpi_pkg::DIV_IDLE;
			target_row <= '0;
			target_col <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mfpi_pkg::DIV_RUN && last_step) begin
				// The index must not be negative and the quotient must land inside the matrix, else element (0,0) is used.
				if (index[31] || rows == '0 || cols == '0 ||
				    quot_next >= 31'(rows)) begin
					target_row <= '0;
					target_col <= '0;
				end else begin
					target_row <= quot_next[mfpi_pkg::POS_W-1:0];
					target_col <= rem_next[mfpi_pkg::POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mfpi_pkg::DIV_LOAD) begin
			quot_q <= index[30:0];
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (state_q == mfpi_pkg::DIV_RUN) begin
			quot_q <= quot_next;
			rem_q  <= rem_next;
			cnt_q  <= cnt_q + 5'd1;
		end
	end

endmodule

/* hdl/mfpi_fadd.sv */
// Two-stage IEEE single precision adder with round to nearest even.
module mfpi_fadd (
	input  logic               clk,
	input  mfpi_pkg::pipe_en_t en,
	input  logic [31:0]        x_s1,
	input  logic [31:0]        delta,
	input  mfpi_pkg::op_t      op_s1,
	output logic [31:0]        result_s3
);

	logic [31:0] b;
	logic        a_nan, b_nan, a_inf, b_inf, d_nan;
	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  e_big, e_sml, diff;
	logic [26:0] ext_big, ext_sml, shifted, mask;
	logic        sticky;
	logic [26:0] aligned;
	logic        eff_sub;
	logic [27:0] sum;
	logic        special;
	logic [31:0] special_val;

	logic        special_s2;
	logic [31:0] special_val_s2;
	logic [27:0] sum_s2;
	logic [7:0]  e_s2;
	logic        sign_s2;
	logic        zero_sign_s2;

	logic [4:0]  lz;
	logic [7:0]  sh;
	logic [26:0] norm;
	logic [8:0]  e9;
	logic [7:0]  field;
	logic        round_up;
	logic [30:0] packed_val;
	logic [31:0] result_d;

	assign b = (op_s1 == mfpi_pkg::OP_SUB) ? {~delta[31], delta[30:0]} : delta;
	assign a_nan = (x_s1[30:23] == 8'hFF) && (x_s1[22:0] != '0);
	assign d_nan = (delta[30:23] == 8'hFF) && (delta[22:0] != '0);
	assign b_nan = d_nan;
	assign a_inf = (x_s1[30:23] == 8'hFF) && (x_s1[22:0] == '0);
	assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);

	always_comb begin
		special = 1'b1;
		special_val = x_s1;
		if (op_s1 == mfpi_pkg::OP_NONE) begin
			special_val = x_s1;
		end else if (a_nan) begin
			special_val = x_s1 | mfpi_pkg::QUIET_BIT;
		end else if (b_nan) begin
			// The delta keeps its own sign even when it is subtracted.
			special_val = delta | mfpi_pkg::QUIET_BIT;
		end else if (a_inf && b_inf && (x_s1[31] != b[31])) begin
			special_val = mfpi_pkg::QNAN_DEFAULT;
		end else if (a_inf) begin
			special_val = x_s1;
		end else if (b_inf) begin
			special_val = b;
		end else begin
			special = 1'b0;
		end
	end

	assign swap = (x_s1[30:0] < b[30:0]);
	assign big = swap ? b : x_s1;
	assign sml = swap ? x_s1 : b;
	assign e_big = (big[30:23] == '0) ? 8'd1 : big[30:23];
	assign e_sml = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
	assign diff = e_big - e_sml;
	assign ext_big = {(big[30:23] != '0), big[22:0], 3'b000};
	assign ext_sml = {(sml[30:23] != '0), sml[22:0], 3'b000};
	assign mask = ~({27{1'b1}} << diff[4:0]);

	always_comb begin
		if (diff >= 8'd27) begin
			shifted = '0;
			sticky = |ext_sml;
		end else begin
			shifted = ext_sml >> diff[4:0];
			sticky = |(ext_sml & mask);
		end
	end

	assign aligned = {shifted[26:1], shifted[0] | sticky};
	assign eff_sub = (big[31] != sml[31]);
	assign sum = eff_sub ? ({1'b0, ext_big} - {1'b0, aligned})
	                     : ({1'b0, ext_big} + {1'b0, aligned});

	always_ff @(posedge clk) begin
		if (en.s2) begin
			special_s2     <= special;
			special_val_s2 <= special_val;
			sum_s2         <= sum;
			e_s2           <= e_big;
			sign_s2        <= big[31];
			zero_sign_s2   <= eff_sub ? 1'b0 : big[31];
		end
	end

	always_comb begin
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (sum_s2[i]) lz = 5'(26 - i);
		end
	end

	always_comb begin
		sh = ({3'b000, lz} < (e_s2 - 8'd1)) ? {3'b000, lz} : (e_s2 - 8'd1);
		if (sum_s2[27]) begin
			norm = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			e9 = {1'b0, e_s2} + 9'd1;
		end else begin
			norm = sum_s2[26:0] << sh[4:0];
			e9 = {1'b0, e_s2} - {1'b0, sh};
		end
		field = norm[26] ? e9[7:0] : 8'd0;
		round_up = norm[2] & (norm[1] | norm[0] | norm[3]);
		// A carry out of the fraction moves into the exponent on its own.
		packed_val = {field, norm[25:3]} + 31'(round_up);
		if (special_s2) begin
			result_d = special_val_s2;
		end else if (sum_s2 == '0) begin
			result_d = {zero_sign_s2, 31'd0};
		end else if (e9 >= 9'd255) begin
			result_d = {sign_s2, 8'hFF, 23'd0};
		end else begin
			result_d = {sign_s2, packed_val};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) result_s3 <= result_d;
	end

endmodule

/* hdl/matrix_fault_pattern_injector_core.sv */
// Top level: configuration, stream position, pattern decision and output pipeline.
// An input transfer passes through registered stages to its result; one element per cycle unless stalled.
// The adder takes two of those stages, the pattern decision the first.
// A write of the target index or a matrix size runs the iterative target divider,
// during which inputs are stalled and configuration is not ready.
// Reset clears the configuration, position and valid registers; delta resets to 1.0.
module matrix_fault_pattern_injector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] element_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits,
	output logic        last_element,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW = mfpi_pkg::CNT_W;
	localparam int PW = mfpi_pkg::POS_W;

	logic          enable_q;
	logic [1:0]    mode_q;
	logic [31:0]   delta_q;
	logic [31:0]   index_q;
	logic [CW-1:0] rows_cfg_q, cols_cfg_q;
	logic [CW-1:0] m, n;
	logic [PW-1:0] row_q, col_q;
	logic [PW-1:0] target_row, target_col;
	logic          busy;
	logic          cfg_write, div_start, size_write;
	logic          in_accept;

	logic v1_q, v2_q, v3_q;
	logic ready1, ready2, ready3;
	mfpi_pkg::pipe_en_t en;

	logic [31:0]    x_s1;
	mfpi_pkg::op_t  op_s1;
	logic           last_s1, last_s2;
	mfpi_pkg::op_t  op_d;
	logic           last_d;

	logic [CW-1:0] r, c, tr, tc, i0, j0, r_even, c_even;
	logic          row_ok, col_ok;
	logic          minus, plus;

	assign cfg_ready  = !busy;
	assign cfg_write  = cfg_valid && cfg_ready;
	assign size_write = cfg_write && (cfg_index == mfpi_pkg::REG_ROWS ||
	                                  cfg_index == mfpi_pkg::REG_COLS);
	assign div_start  = size_write || (cfg_write && cfg_index == mfpi_pkg::REG_INDEX);

	assign m = (rows_cfg_q > mfpi_pkg::ROWS_LIMIT) ? mfpi_pkg::ROWS_LIMIT : rows_cfg_q;
	assign n = (cols_cfg_q > mfpi_pkg::COLS_LIMIT) ? mfpi_pkg::COLS_LIMIT : cols_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			mode_q     <= '0;
			delta_q    <= mfpi_pkg::DELTA_RESET;
			index_q    <= '0;
			rows_cfg_q <= '0;
			cols_cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mfpi_pkg::REG_ENABLE: enable_q   <= cfg_data[0];
				mfpi_pkg::REG_MODE:   mode_q     <= cfg_data[1:0];
				mfpi_pkg::REG_DELTA:  delta_q    <= cfg_data;
				mfpi_pkg::REG_INDEX:  index_q    <= cfg_data;
				mfpi_pkg::REG_ROWS:   rows_cfg_q <= cfg_data[CW-1:0];
				mfpi_pkg::REG_COLS:   cols_cfg_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	mfpi_target u_target (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.index      (index_q),
		.rows       (m),
		.cols       (n),
		.busy       (busy),
		.target_row (target_row),
		.target_col (target_col)
	);

	// Each stage takes a new transfer when it is empty or its successor moves.
	assign ready3 = !v3_q || !out_stall;
	assign ready2 = !v2_q || ready3;
	assign ready1 = !v1_q || ready2;
	assign in_stall = busy || !ready1;
	assign in_accept = in_valid && !in_stall;
	assign en.s2 = ready2;
	assign en.s3 = ready3;

	assign r  = {1'b0, row_q};
	assign c  = {1'b0, col_q};
	assign tr = {1'b0, target_row};
	assign tc = {1'b0, target_col};
	assign i0 = (tr >= m - CW'(1)) ? m - CW'(2) : tr;
	assign j0 = (tc >= n - CW'(1)) ? n - CW'(2) : tc;
	assign r_even = {r[CW-1:1], 1'b0};
	assign c_even = {c[CW-1:1], 1'b0};
	assign row_ok = (r_even + CW'(1)) < m;
	assign col_ok = (c_even + CW'(1)) < n;

	always_comb begin
		minus = 1'b0;
		plus = 1'b0;
		case (mode_q)
			mfpi_pkg::MODE_TRIVIAL: begin
				if (m == CW'(1) && n == CW'(1)) begin
					minus = 1'b0;
				end else if (m == CW'(1)) begin
					minus = (c == j0);
					plus  = (c == j0 + CW'(1));
				end else if (n == CW'(1)) begin
					minus = (r == i0);
					plus  = (r == i0 + CW'(1));
				end else if ((r == i0 || r == i0 + CW'(1)) &&
				             (c == j0 || c == j0 + CW'(1))) begin
					minus = ((r == i0) == (c == j0));
					plus  = !minus;
				end
			end
			mfpi_pkg::MODE_CHECKERED: begin
				if (m == CW'(1) && n == CW'(1)) begin
					minus = 1'b0;
				end else if (m == CW'(1)) begin
					minus = col_ok && !c[0];
					plus  = col_ok && c[0];
				end else if (n == CW'(1)) begin
					minus = row_ok && !r[0];
					plus  = row_ok && r[0];
				end else if (row_ok && col_ok) begin
					minus = (r[0] == c[0]);
					plus  = !minus;
				end
			end
			default: begin
				plus = (row_q == target_row) && (col_q == target_col);
			end
		endcase
	end

	always_comb begin
		op_d = mfpi_pkg::OP_NONE;
		last_d = 1'b0;
		if (m != '0 && n != '0) begin
			last_d = (r == m - CW'(1)) && (c == n - CW'(1));
			if (enable_q && minus) op_d = mfpi_pkg::OP_SUB;
			else if (enable_q && plus) op_d = mfpi_pkg::OP_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (size_write) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_accept && m != '0 && n != '0) begin
			if (c + CW'(1) >= n) begin
				col_q <= '0;
				row_q <= (r + CW'(1) >= m) ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (ready1) v1_q <= in_accept;
			if (ready2) v2_q <= v1_q;
			if (ready3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			x_s1    <= element_bits;
			op_s1   <= op_d;
			last_s1 <= last_d;
		end
		if (ready2) last_s2 <= last_s1;
		if (ready3) last_element <= last_s2;
	end

	mfpi_fadd u_fadd (
		.clk       (clk),
		.en        (en),
		.x_s1      (x_s1),
		.delta     (delta_q),
		.op_s1     (op_s1),
		.result_s3 (result_bits)
	);

	assign out_valid = v3_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input taken while the target divider runs");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n != '0) |-> (c < n))
		else $error("column position outside the matrix");

	a_zero_size_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (m == '0 || n == '0) && !size_write) |=>
		($stable(row_q) && $stable(col_q)))
		else $error("position moved for a zero-size matrix");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> busy)
		else $error("target divider did not start after a write");

endmodule
